// ----- design/dwq_pkg.sv -----
// Package for the deduplicating work queue.
// Sizes, operation and status codes, and the controller/datapath command and
// status structs. No dependencies.
package dwq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W = 64;
    localparam int OP_W = 2;
    localparam int ST_W = 3;
    localparam int OCC_W = 8;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_POP = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic            load;        // capture request, read entry 0
        logic            advance;     // step scan index, read next entry
        logic            shift_wr;    // move current entry one slot toward head
        logic            append;      // write id at tail, grow count
        logic            remove;      // shrink count
        logic            capture_pop; // keep current entry as popped id
        logic            res_we;      // latch result status
        logic [ST_W-1:0] res_status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            full;
        logic            match;       // current entry equals request id
        logic            last;        // current entry is the youngest one
    } stat_t;

endpackage

// ----- design/dwq_req_if.sv -----
// Request channel of the work queue: valid/ready with operation and id.
// Depends on dwq_pkg.
interface dwq_req_if
    import dwq_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] item_id;

    modport source (output valid, output operation, output item_id, input ready);
    modport sink (input valid, input operation, input item_id, output ready);
endinterface

// ----- design/dwq_rsp_if.sv -----
// Response channel of the work queue: valid/ready with status, popped id and
// occupancy. Depends on dwq_pkg.
interface dwq_rsp_if
    import dwq_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  popped_id;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output popped_id, output occupancy,
                    input ready);
    modport sink (input valid, input status, input popped_id, input occupancy,
                  output ready);
endinterface

// ----- design/dedup_work_queue.sv -----
// Deduplicating work queue: ordered set of 64-bit ids with add, pop, delete.
// An unused code or an empty queue is answered straight from the first scan
// step; add and delete scan one entry a cycle, and pop or delete then compact
// one entry a cycle through the separate read and write ports of the memory.
// One transaction at a time; a new request is taken the cycle after the
// response leaves. Asynchronous reset empties the queue; entries stay unset.
module dedup_work_queue
    import dwq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dwq_req_if.sink   req,
    dwq_rsp_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;

    dwq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dwq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_operation (req.operation),
        .in_item_id   (req.item_id),
        .cmd          (cmd),
        .stat         (stat),
        .status       (rsp.status),
        .popped_id    (rsp.popped_id),
        .occupancy    (rsp.occupancy)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken while a response is pending");

    a_accept_then_work: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (!rsp.valid && !req.ready))
        else $error("response or ready right after a request");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0 && rsp.popped_id == '0))
        else $error("empty pop reports entries or an id");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(QUEUE_DEPTH)))
        else $error("full drop reported below capacity");
`endif

endmodule

// ----- design/dwq_dp.sv -----
// Datapath of the work queue: entry memory, scan index, count and result
// registers. Driven by dwq_ctrl through cmd_t; depends on dwq_pkg.
module dwq_dp
    import dwq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [OP_W-1:0]  in_operation,
    input  logic [ID_W-1:0]  in_item_id,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic [ST_W-1:0]  status,
    output logic [ID_W-1:0]  popped_id,
    output logic [OCC_W-1:0] occupancy
);

    logic [ID_W-1:0]  mem [QUEUE_DEPTH];

    logic [OP_W-1:0]  op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ID_W-1:0]  rd_data_reg;
    logic [ST_W-1:0]  status_reg;
    logic [ID_W-1:0]  popped_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ID_W-1:0]  wr_data;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // rd_data_reg always holds the entry at idx_reg while scanning
    assign rd_en = cmd.load | cmd.advance;
    assign rd_addr = idx_next;

    assign wr_en = cmd.shift_wr | cmd.append;
    assign wr_addr = cmd.append ? count_reg[IDX_W-1:0] : idx_reg - IDX_W'(1);
    assign wr_data = cmd.append ? id_reg : rd_data_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_operation;
            id_reg <= in_item_id;
        end
        if (cmd.res_we)
        begin
            status_reg <= cmd.res_status;
        end
        if (cmd.load)
        begin
            popped_reg <= '0;
        end
        else if (cmd.capture_pop)
        begin
            popped_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    assign stat.op = op_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.match = (rd_data_reg == id_reg);
    assign stat.last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign status = status_reg;
    assign popped_id = popped_reg;
    assign occupancy = OCC_W'(count_reg);

endmodule

// ----- design/dwq_ctrl.sv -----
// Controller of the work queue: sequences scan, compaction and response.
// Commands dwq_dp through cmd_t; depends on dwq_pkg.
module dwq_ctrl
    import dwq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Latch a result status; the caller moves to the response state
    function automatic cmd_t finish(input cmd_t c, input logic [ST_W-1:0] st);
        cmd_t r;
        r = c;
        r.res_we = 1'b1;
        r.res_status = st;
        return r;
    endfunction

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.append = 1'b1;
                            cmd = finish(cmd, ST_DONE);
                            state_next = S_RESP;
                        end
                        else if (stat.match)
                        begin
                            cmd = finish(cmd, ST_PRESENT);
                            state_next = S_RESP;
                        end
                        else if (stat.last)
                        begin
                            if (stat.full)
                            begin
                                cmd = finish(cmd, ST_FULL);
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                cmd = finish(cmd, ST_DONE);
                            end
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        // head entry is the one removed
                        if (stat.count_zero)
                        begin
                            cmd = finish(cmd, ST_EMPTY);
                            state_next = S_RESP;
                        end
                        else if (stat.last)
                        begin
                            cmd.capture_pop = 1'b1;
                            cmd.remove = 1'b1;
                            cmd = finish(cmd, ST_DONE);
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.capture_pop = 1'b1;
                            cmd.advance = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_DEL:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd = finish(cmd, ST_NOT_FOUND);
                            state_next = S_RESP;
                        end
                        else if (stat.match)
                        begin
                            if (stat.last)
                            begin
                                cmd.remove = 1'b1;
                                cmd = finish(cmd, ST_DONE);
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.advance = 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        else if (stat.last)
                        begin
                            cmd = finish(cmd, ST_NOT_FOUND);
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd = finish(cmd, ST_DONE);
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // move the current entry one slot toward the head
                cmd.shift_wr = 1'b1;
                if (stat.last)
                begin
                    cmd.remove = 1'b1;
                    cmd = finish(cmd, ST_DONE);
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_ready  <= (state_next == S_IDLE);
            out_valid <= (state_next == S_RESP);
        end
    end

endmodule

// ----- verif/dedup_work_queue_test.sv -----
// Self-checking testbench for dedup_work_queue: directed and random add, pop and delete traffic,
// plus unused operation codes, checked against a queue-based predictor of the stored identifiers.
// Depends on dwq_pkg, dwq_req_if, dwq_rsp_if and the dedup_work_queue RTL.
`timescale 1ns / 1ps

module dedup_work_queue_test
    import dwq_pkg::*;
;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [ID_W-1:0] ALL_ONES = '1;
    localparam logic [ID_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [ID_W-1:0] ALT_BITS = 64'h5555_5555_5555_5555;
    localparam int RUN_ITEMS = 1900;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE = 160;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 20;
    localparam int MAX_PRINTS = 200;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  popped_id;
        logic [OCC_W-1:0] occupancy;
    } queue_result_t;

    typedef enum int {MIX_OPS, FILL_OPS, DRAIN_OPS} burst_kind_t;

    class dwq_scoreboard;
        logic [ID_W-1:0] held[$];
        queue_result_t   awaited[$];
        int              errors;

        function new();
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Apply one accepted request to the shadow queue and queue its response.
        function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
            queue_result_t res;
            int            pos;
            res = '0;
            res.status = ST_DONE;
            pos = -1;
            foreach (held[i])
                if (pos < 0 && held[i] == id)
                    pos = i;
            case (op)
                OP_ADD:
                    if (pos >= 0)
                        res.status = ST_PRESENT;
                    else if (held.size() >= QUEUE_DEPTH)
                        res.status = ST_FULL;
                    else
                        held = {held, id};
                OP_POP:
                    if (held.size() == 0)
                        res.status = ST_EMPTY;
                    else
                        res.popped_id = held.pop_front();
                OP_DEL:
                    if (pos >= 0)
                        held.delete(pos);
                    else
                        res.status = ST_NOT_FOUND;
                default:
                    ;
            endcase
            res.occupancy = OCC_W'(held.size());
            awaited = {awaited, res};
        endfunction

        task check_result(queue_result_t got);
            queue_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("response with none outstanding: status %0d id %h occ %0d",
                                 got.status, got.popped_id, got.occupancy));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.popped_id !== want.popped_id)
                report($sformatf("popped_id %h, expected %h", got.popped_id, want.popped_id));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
        endtask

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dwq_req_if req_ch ();
    dwq_rsp_if rsp_ch ();

    dedup_work_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dwq_scoreboard   queue_sb;
    logic [ID_W-1:0] id_pool[POOL_SIZE];
    int              send_idle_pct = 31;
    int              recv_idle_pct = 75;
    int              hold_requests = 0;
    int              holds_served = 0;
    int              hold_left = 0;
    int              items_sent = 0;
    int              cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [ID_W-1:0] random_id();
        return {$urandom, $urandom};
    endfunction

    // Held ids (held_pct percent), fresh ids (10 percent) or pool ids, so duplicates and hits happen.
    function automatic logic [ID_W-1:0] pick_id(int held_pct);
        int r;
        r = $urandom_range(99);
        if (r < held_pct && queue_sb.held.size() > 0)
            return queue_sb.held[$urandom_range(queue_sb.held.size() - 1)];
        if (r < held_pct + 10)
            return random_id();
        return id_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [OP_W-1:0] pick_op(burst_kind_t kind);
        int r;
        int add_pct;
        int pop_pct;
        r = $urandom_range(99);
        case (kind)
            FILL_OPS:
            begin
                add_pct = 80;
                pop_pct = 8;
            end
            DRAIN_OPS:
            begin
                add_pct = 5;
                pop_pct = 45;
            end
            default:
            begin
                add_pct = 40;
                pop_pct = 25;
            end
        endcase
        if (r < add_pct)
            return OP_ADD;
        if (r < add_pct + pop_pct)
            return OP_POP;
        if (r < 95)
            return OP_DEL;
        return OP_UNUSED;
    endfunction

    // Offer one transaction; return at the edge where it is accepted.
    task automatic submit(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.item_id <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        queue_sb.note_request(op, id);
        items_sent++;
    endtask

    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (queue_sb.outstanding() > 0)
            @(posedge clk);
    endtask

    task automatic run_burst(burst_kind_t kind, int len);
        int held_pct;
        case (kind)
            FILL_OPS:  held_pct = 10;
            DRAIN_OPS: held_pct = 70;
            default:   held_pct = 35;
        endcase
        for (int n = 0; n < len; n++)
            submit(pick_op(kind), pick_id(held_pct));
    endtask

    // Grow toward capacity (at most 400 requests), hit it with a duplicate and a new id, then a fill burst.
    task automatic fill_to_full();
        int guard;
        guard = 0;
        while (queue_sb.held.size() < QUEUE_DEPTH && guard < 400)
        begin
            submit(pick_op(FILL_OPS), pick_id(10));
            guard++;
        end
        if (queue_sb.held.size() > 0)
            submit(OP_ADD, queue_sb.held[$urandom_range(queue_sb.held.size() - 1)]);
        submit(OP_ADD, random_id());
        run_burst(FILL_OPS, 10);
    endtask

    task automatic run_directed();
        submit(OP_POP, ALL_ONES);
        submit(OP_DEL, '0);
        submit(OP_UNUSED, ALL_ONES);
        submit(OP_ADD, '0);
        submit(OP_ADD, ALL_ONES);
        submit(OP_ADD, '0);
        submit(OP_ADD, TOP_BIT);
        submit(OP_ADD, 64'd1);
        submit(OP_DEL, ALL_ONES);
        submit(OP_DEL, ALL_ONES);
        submit(OP_POP, '0);
        submit(OP_UNUSED, ALT_BITS);
        submit(OP_ADD, '0);
        submit(OP_ADD, ~ALT_BITS);
        submit(OP_DEL, ~ALT_BITS);
        submit(OP_POP, '0);
        submit(OP_POP, '0);
        submit(OP_POP, '0);
        submit(OP_POP, '0);
        submit(OP_DEL, 64'd1);
    endtask

    initial
    begin
        int phase_end;
        int r;
        queue_sb = new();
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.operation <= OP_ADD;
        req_ch.item_id <= '0;
        rsp_ch.ready <= 1'b0;
        id_pool[0] = '0;
        id_pool[1] = ALL_ONES;
        id_pool[2] = TOP_BIT;
        id_pool[3] = 64'd1;
        for (int i = 4; i < POOL_SIZE; i++)
            id_pool[i] = (i % 8 == 7) ? id_pool[i-1] ^ (64'd1 << $urandom_range(ID_W - 1))
                                      : random_id();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
            begin
                // Pause the sender until everything is back, then stall the receiver.
                wait_quiet();
                hold_requests++;
            end
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 31 : 0;
            phase_end = RUN_ITEMS * (phase + 1) / 3;
            fill_to_full();
            while (items_sent < phase_end)
            begin
                r = $urandom_range(99);
                if (r < 10)
                    fill_to_full();
                else if (r < 35)
                    run_burst(DRAIN_OPS, $urandom_range(10, 60));
                else
                    run_burst(MIX_OPS, $urandom_range(10, 40));
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (queue_sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Response side: random backpressure plus requested long hold-offs.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        queue_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.popped_id = rsp_ch.popped_id;
                got.occupancy = rsp_ch.occupancy;
                queue_sb.check_result(got);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
